// ----- rtl/core/stct_pkg.sv -----
// Shared types and codes for the session traffic counter table.
// No dependencies; imported by the front end, the back end and the top level.
`default_nettype none

package stct_pkg;

  typedef enum logic [2:0] {
    OP_ATTACH,
    OP_DETACH,
    OP_UPLINK,
    OP_DOWNLINK,
    OP_SET_QOS,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_ALREADY   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [31:0] session_id;
    logic [31:0] ue_id;
    logic [15:0] packet_bytes;
    logic [31:0] qos_kbps;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  active_sessions;
    logic [63:0] total_downlink_bytes;
    logic [63:0] total_uplink_bytes;
    logic [31:0] qos_rate_kbps;
    logic [63:0] downlink_bytes;
    logic [63:0] uplink_bytes;
    logic [31:0] ue_of_session;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/stct_front.sv -----
// Front end: accepts input transactions, decodes the kind into an operation
// and holds them in a short queue for the back end. Depends on stct_pkg.
`default_nettype none

module stct_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [111:0]   s_tdata,   // session_id, ue_id, packet_bytes, qos_kbps
  input  logic [2:0]     s_tuser,   // kind
  output logic           cmd_valid,
  output stct_pkg::cmd_t cmd,
  input  logic           cmd_pop
);
  import stct_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [2:0] KIND_ATTACH   = 3'd0;
  localparam logic [2:0] KIND_DETACH   = 3'd1;
  localparam logic [2:0] KIND_UPLINK   = 3'd2;
  localparam logic [2:0] KIND_DOWNLINK = 3'd3;
  localparam logic [2:0] KIND_SET_QOS  = 3'd4;
  localparam logic [2:0] KIND_QUERY    = 3'd5;
  localparam logic [2:0] KIND_CLEAR    = 3'd6;

  cmd_t           q [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           push;
  cmd_t           in_cmd;
  op_t            in_op;

  always_comb begin
    case (s_tuser)
      KIND_ATTACH:   in_op = OP_ATTACH;
      KIND_DETACH:   in_op = OP_DETACH;
      KIND_UPLINK:   in_op = OP_UPLINK;
      KIND_DOWNLINK: in_op = OP_DOWNLINK;
      KIND_SET_QOS:  in_op = OP_SET_QOS;
      KIND_QUERY:    in_op = OP_QUERY;
      KIND_CLEAR:    in_op = OP_CLEAR;
      default:       in_op = OP_QUERY;  // unused code reads as a query
    endcase
  end

  assign in_cmd = '{op:           in_op,
                    session_id:   s_tdata[31:0],
                    ue_id:        s_tdata[63:32],
                    packet_bytes: s_tdata[79:64],
                    qos_kbps:     s_tdata[111:80]};

  assign s_tready  = count != (QAW + 1)'(QUEUE_DEPTH);
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = count != '0;
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        q[wptr] <= in_cmd;
        if (wptr == QAW'(QUEUE_DEPTH - 1)) begin
          wptr <= '0;
        end else begin
          wptr <= wptr + QAW'(1);
        end
      end
      if (cmd_pop) begin
        if (rptr == QAW'(QUEUE_DEPTH - 1)) begin
          rptr <= '0;
        end else begin
          rptr <= rptr + QAW'(1);
        end
      end
      if (push && !cmd_pop) begin
        count <= count + (QAW + 1)'(1);
      end else if (!push && cmd_pop) begin
        count <= count - (QAW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stct_back.sv -----
// Back end: session memory, linear key scan, counter update and result
// register. Depends on stct_pkg; fed by stct_front.
`default_nettype none

module stct_back #(
  parameter int SESSIONS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  stct_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output stct_pkg::res_t out_res
);
  import stct_pkg::*;

  localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CW = $clog2(SESSIONS + 1);
  localparam logic [IW-1:0] LAST = IW'(SESSIONS - 1);
  localparam logic [31:0] DEFAULT_RATE_KBPS = 32'd1000;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] ue;
    logic [63:0] up;
    logic [63:0] dn;
    logic [31:0] rate;
  } entry_t;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_SCAN, S_CLEAR, S_APPLY} state_t;

  entry_t        mem [SESSIONS];
  entry_t        rdata;
  entry_t        hit_entry;
  entry_t        wdata;
  entry_t        apply_entry;
  entry_t        shown;
  logic [IW-1:0] raddr;
  logic [IW-1:0] chk_idx;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] sweep_idx;
  logic [IW-1:0] waddr;
  logic [IW-1:0] apply_idx;
  logic          issuing;
  logic          chk_ok;
  logic          hit;
  logic          free_found;
  logic          we;
  logic          apply_we;
  logic          show;
  logic          match;
  logic          out_free;
  logic [1:0]    status_next;
  cmd_t          cur;
  logic [63:0]   sum_up;
  logic [63:0]   sum_dn;
  logic [63:0]   sum_up_next;
  logic [63:0]   sum_dn_next;
  logic [CW-1:0] live;
  logic [CW-1:0] live_next;
  logic [CW+6:0] live_ext;
  res_t          res_next;
  state_t        state;

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign match    = chk_ok && rdata.valid && (rdata.key == cur.session_id);

  always_comb begin
    apply_we    = 1'b0;
    apply_idx   = hit_idx;
    apply_entry = hit_entry;
    sum_up_next = sum_up;
    sum_dn_next = sum_dn;
    live_next   = live;
    status_next = ST_OK;
    show        = 1'b0;
    shown       = hit_entry;
    case (cur.op)
      OP_ATTACH: begin
        if (hit) begin
          status_next = ST_ALREADY;
          show        = 1'b1;
        end else if (free_found) begin
          apply_we    = 1'b1;
          apply_idx   = free_idx;
          apply_entry = '{valid: 1'b1, key: cur.session_id, ue: cur.ue_id,
                          up: 64'd0, dn: 64'd0, rate: DEFAULT_RATE_KBPS};
          live_next   = live + CW'(1);
          show        = 1'b1;
          shown       = apply_entry;
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_DETACH: begin
        if (hit) begin
          apply_we          = 1'b1;
          apply_entry.valid = 1'b0;
          live_next         = live - CW'(1);
          show              = 1'b1;  // entry as it stood before freeing
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_UPLINK: begin
        if (hit) begin
          apply_we       = 1'b1;
          apply_entry.up = hit_entry.up + {48'd0, cur.packet_bytes};
          sum_up_next    = sum_up + {48'd0, cur.packet_bytes};
          show           = 1'b1;
          shown          = apply_entry;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_DOWNLINK: begin
        if (hit) begin
          apply_we       = 1'b1;
          apply_entry.dn = hit_entry.dn + {48'd0, cur.packet_bytes};
          sum_dn_next    = sum_dn + {48'd0, cur.packet_bytes};
          show           = 1'b1;
          shown          = apply_entry;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_SET_QOS: begin
        if (hit) begin
          apply_we         = 1'b1;
          apply_entry.rate = cur.qos_kbps;
          show             = 1'b1;
          shown            = apply_entry;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        live_next = '0;  // entries already swept
      end
      default: begin
        if (hit) begin
          show = 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
    endcase
  end

  assign live_ext = {7'd0, live_next};

  always_comb begin
    res_next.status               = status_next;
    res_next.ue_of_session        = show ? shown.ue   : 32'd0;
    res_next.uplink_bytes         = show ? shown.up   : 64'd0;
    res_next.downlink_bytes       = show ? shown.dn   : 64'd0;
    res_next.qos_rate_kbps        = show ? shown.rate : 32'd0;
    res_next.total_uplink_bytes   = sum_up_next;
    res_next.total_downlink_bytes = sum_dn_next;
    res_next.active_sessions      = live_ext[6:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = apply_idx;
    wdata = apply_entry;
    if (state == S_INIT || state == S_CLEAR) begin
      we    = 1'b1;
      waddr = sweep_idx;
      wdata = '0;
    end else if (state == S_APPLY && out_free && apply_we) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep_idx  <= '0;
      raddr      <= '0;
      issuing    <= 1'b0;
      chk_ok     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
      sum_up     <= '0;
      sum_dn     <= '0;
      live       <= '0;
    end else begin
      chk_ok  <= issuing;
      chk_idx <= raddr;
      if (state == S_APPLY && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (sweep_idx == LAST) begin
            sweep_idx <= '0;
            state     <= S_IDLE;
          end else begin
            sweep_idx <= sweep_idx + IW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur        <= cmd;
            hit        <= 1'b0;
            free_found <= 1'b0;
            if (cmd.op == OP_CLEAR) begin
              sweep_idx <= '0;
              state     <= S_CLEAR;
            end else begin
              raddr   <= '0;
              issuing <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match || (chk_ok && chk_idx == LAST)) begin
            issuing <= 1'b0;
            state   <= S_APPLY;
          end else if (issuing) begin
            if (raddr == LAST) begin
              issuing <= 1'b0;
            end else begin
              raddr <= raddr + IW'(1);
            end
          end
          if (match) begin
            hit       <= 1'b1;
            hit_idx   <= chk_idx;
            hit_entry <= rdata;
          end else if (chk_ok && !rdata.valid && !free_found) begin
            // lowest free slot, kept for a possible attach
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
        end
        S_CLEAR: begin
          if (sweep_idx == LAST) begin
            sweep_idx <= '0;
            state     <= S_APPLY;
          end else begin
            sweep_idx <= sweep_idx + IW'(1);
          end
        end
        S_APPLY: begin
          if (out_free) begin
            out_res   <= res_next;
            sum_up    <= sum_up_next;
            sum_dn    <= sum_dn_next;
            live      <= live_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/session_traffic_counter_table.sv -----
// Session traffic counter table: keyed session store with per-session and
// global uplink/downlink byte counters and a QoS rate per session. Input
// transactions enter a two-deep queue; the back end scans the session memory
// one entry per cycle through its single read port, stopping at the matching
// key. A match ends the scan at its entry, and the item goes on to the
// result register; a miss (and any attach of a new id) scans every entry,
// and a clear sweeps the whole memory. The result register waits for the
// previous result to be taken. After reset a clearing pass over all
// SESSIONS entries runs before the first item is served; input transactions
// are still queued meanwhile. Depends on stct_pkg, stct_front and stct_back.
`default_nettype none

module session_traffic_counter_table #(
  parameter int SESSIONS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // session_id[31:0], ue_id[63:32], packet_bytes[79:64], qos_kbps[111:80]
  input  logic [111:0] s_tdata,
  // kind[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], ue_of_session[33:2], uplink_bytes[97:34],
  // downlink_bytes[161:98], qos_rate_kbps[193:162],
  // total_uplink_bytes[257:194], total_downlink_bytes[321:258],
  // active_sessions[328:322], zero fill[335:329]
  output logic [335:0] m_tdata
);
  import stct_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t out_res;

  stct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  stct_back #(
    .SESSIONS (SESSIONS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {7'd0, out_res};

`ifndef SYNTHESIS
  a_push_queued: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> cmd_valid)
    else $error("accepted transaction not visible in queue");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status == ST_FULL |-> out_res.active_sessions == 7'(SESSIONS))
    else $error("table full reported with free entries");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status == ST_NOT_FOUND |->
      out_res.ue_of_session == 32'd0 && out_res.uplink_bytes == 64'd0 &&
      out_res.downlink_bytes == 64'd0 && out_res.qos_rate_kbps == 32'd0)
    else $error("missing session shows entry fields");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_session_traffic_counter_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for session_traffic_counter_table: directed, table-full,
// back-pressure and random transaction streams against a behavioural session table.
// Depends on stct_pkg and the session_traffic_counter_table RTL.

module tb_session_traffic_counter_table;
  import stct_pkg::*;

  localparam int SESSIONS = 64;
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int KEY_POOL = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRESSURE_HOLD = 400;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [335:0] m_tdata;

  session_traffic_counter_table #(.SESSIONS(SESSIONS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Behavioural copy of the session table
  logic        tbl_valid [SESSIONS];
  logic [31:0] tbl_key   [SESSIONS];
  logic [31:0] tbl_ue    [SESSIONS];
  logic [63:0] tbl_up    [SESSIONS];
  logic [63:0] tbl_down  [SESSIONS];
  logic [31:0] tbl_rate  [SESSIONS];
  logic [63:0] sum_up = '0;
  logic [63:0] sum_down = '0;
  int          live_cnt = 0;

  res_t        pending_reports [$];
  logic [31:0] key_pool [KEY_POOL];
  int          fail_count = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          sink_hold = 0;
  int          stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SESSIONS; i++) tbl_valid[i] = 1'b0;
  end

  // Expected report for one command; updates the table copy as a side effect
  function automatic res_t apply_session_op(input logic [2:0] kind, input logic [31:0] sid,
                                            input logic [31:0] ue, input logic [15:0] nbytes,
                                            input logic [31:0] qos);
    res_t r;
    int   hit;
    int   slot;
    int   shown;
    r = '0;
    hit = -1;
    slot = -1;
    shown = -1;
    r.status = ST_OK;
    for (int i = 0; i < SESSIONS; i++)
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == sid) hit = i;
    case (kind)
      OP_ATTACH: begin
        if (hit >= 0) begin
          r.status = ST_ALREADY;
          shown = hit;
        end else begin
          for (int i = 0; i < SESSIONS; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot] = sid;
            tbl_ue[slot] = ue;
            tbl_up[slot] = '0;
            tbl_down[slot] = '0;
            tbl_rate[slot] = 32'd1000;
            live_cnt++;
            shown = slot;
          end
        end
      end
      OP_DETACH: begin
        // fields stay intact after the valid bit drops, so the report shows the old entry
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          tbl_valid[hit] = 1'b0;
          live_cnt--;
          shown = hit;
        end
      end
      OP_UPLINK, OP_DOWNLINK: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          if (kind == OP_UPLINK) begin
            tbl_up[hit] = tbl_up[hit] + 64'(nbytes);
            sum_up = sum_up + 64'(nbytes);
          end else begin
            tbl_down[hit] = tbl_down[hit] + 64'(nbytes);
            sum_down = sum_down + 64'(nbytes);
          end
          shown = hit;
        end
      end
      OP_SET_QOS: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          tbl_rate[hit] = qos;
          shown = hit;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SESSIONS; i++) tbl_valid[i] = 1'b0;
        live_cnt = 0;
      end
      default: begin
        // query, and the unused code which acts as one
        if (hit < 0) r.status = ST_NOT_FOUND;
        else shown = hit;
      end
    endcase
    if (shown >= 0) begin
      r.ue_of_session = tbl_ue[shown];
      r.uplink_bytes = tbl_up[shown];
      r.downlink_bytes = tbl_down[shown];
      r.qos_rate_kbps = tbl_rate[shown];
    end
    r.total_uplink_bytes = sum_up;
    r.total_downlink_bytes = sum_down;
    r.active_sessions = 7'(live_cnt);
    return r;
  endfunction

  // Entered and left at a falling edge; valid stays high for a back-to-back transaction
  task automatic offer_session_cmd(input logic [2:0] kind, input logic [31:0] sid,
                                   input logic [31:0] ue, input logic [15:0] nbytes,
                                   input logic [31:0] qos);
    res_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tuser = kind;
    s_tdata = {qos, nbytes, ue, sid};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    want = apply_session_op(kind, sid, ue, nbytes, qos);
    pending_reports.push_back(want);
    @(negedge clk);
  endtask

  function automatic void refresh_key_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
  endfunction

  task automatic offer_random_cmd();
    logic [2:0]  kind;
    logic [31:0] sid;
    logic [15:0] nbytes;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 20) kind = OP_ATTACH;
    else if (pick < 28) kind = OP_DETACH;
    else if (pick < 53) kind = OP_UPLINK;
    else if (pick < 78) kind = OP_DOWNLINK;
    else if (pick < 86) kind = OP_SET_QOS;
    else if (pick < 94) kind = OP_QUERY;
    else if (pick < 97) kind = OP_CLEAR;
    else kind = KIND_UNUSED;
    if ($urandom_range(9) == 0) sid = $urandom;
    else sid = key_pool[$urandom_range(KEY_POOL - 1)];
    case ($urandom_range(7))
      0: nbytes = '0;
      1: nbytes = '1;
      default: nbytes = 16'($urandom);
    endcase
    offer_session_cmd(kind, sid, $urandom, nbytes, $urandom);
  endtask

  task automatic test_directed();
    // misses on an empty table leave the totals alone
    offer_session_cmd(OP_QUERY, 32'h0, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_DETACH, 32'h0, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_UPLINK, 32'h0, 32'h0, 16'hffff, 32'h0);
    offer_session_cmd(OP_SET_QOS, 32'h0, 32'h0, 16'h0, 32'hffff_ffff);
    offer_session_cmd(OP_ATTACH, 32'h0, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    offer_session_cmd(OP_ATTACH, 32'h0, 32'h1234_5678, 16'h0, 32'h0);
    offer_session_cmd(OP_ATTACH, 32'hffff_ffff, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_UPLINK, 32'h0, 32'h0, 16'hffff, 32'h0);
    offer_session_cmd(OP_UPLINK, 32'h0, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_DOWNLINK, 32'hffff_ffff, 32'h0, 16'hffff, 32'h0);
    offer_session_cmd(OP_DOWNLINK, 32'h5a5a_5a5a, 32'h0, 16'h1, 32'h0);
    offer_session_cmd(OP_SET_QOS, 32'h0, 32'h0, 16'h0, 32'hffff_ffff);
    offer_session_cmd(OP_SET_QOS, 32'hffff_ffff, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_QUERY, 32'h0, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(KIND_UNUSED, 32'hffff_ffff, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(KIND_UNUSED, 32'h0bad_cafe, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_DETACH, 32'h0, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_QUERY, 32'h0, 32'h0, 16'h0, 32'h0);
    // freed slot 0 is the lowest free one again
    offer_session_cmd(OP_ATTACH, 32'h1234_5678, 32'h8765_4321, 16'h0, 32'h0);
    offer_session_cmd(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    offer_session_cmd(OP_QUERY, 32'hffff_ffff, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_ATTACH, 32'h5, 32'h55, 16'h0, 32'h0);
  endtask

  task automatic test_table_full();
    logic [31:0] keys [SESSIONS];
    offer_session_cmd(OP_CLEAR, $urandom, $urandom, 16'h0, $urandom);
    while (live_cnt < SESSIONS) begin
      keys[live_cnt] = $urandom;
      offer_session_cmd(OP_ATTACH, keys[live_cnt], $urandom, 16'h0, 32'h0);
    end
    offer_session_cmd(OP_ATTACH, $urandom, $urandom, 16'h0, 32'h0);
    offer_session_cmd(OP_ATTACH, keys[SESSIONS - 1], $urandom, 16'h0, 32'h0);
    offer_session_cmd(OP_UPLINK, keys[SESSIONS - 1], 32'h0, 16'($urandom), 32'h0);
    offer_session_cmd(OP_DOWNLINK, keys[SESSIONS - 1], 32'h0, 16'($urandom), 32'h0);
    offer_session_cmd(OP_SET_QOS, keys[SESSIONS - 1], 32'h0, 16'h0, $urandom);
    offer_session_cmd(OP_UPLINK, $urandom, 32'h0, 16'hffff, 32'h0);
    offer_session_cmd(OP_DETACH, keys[40], 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_ATTACH, 32'hc0de_0040, $urandom, 16'h0, 32'h0);
    offer_session_cmd(OP_QUERY, 32'hc0de_0040, 32'h0, 16'h0, 32'h0);
    offer_session_cmd(OP_QUERY, keys[SESSIONS - 1], 32'h0, 16'h0, 32'h0);
  endtask

  // Receiver holds off in its own process while commands keep coming
  task automatic test_backpressure();
    refresh_key_pool();
    sink_hold = PRESSURE_HOLD;
    offer_session_cmd(OP_CLEAR, $urandom, $urandom, 16'h0, $urandom);
    repeat (24) offer_random_cmd();
  endtask

  task automatic test_random();
    refresh_key_pool();
    src_idle_pct = 32;
    sink_idle_pct = 87;
    repeat (200) offer_random_cmd();
    refresh_key_pool();
    src_idle_pct = 87;
    sink_idle_pct = 32;
    repeat (200) offer_random_cmd();
    refresh_key_pool();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (200) offer_random_cmd();
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_tready = 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[328:0]);
      if (pending_reports.size() == 0) begin
        $error("result transaction with nothing expected, status %0d", got.status);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("ue_of_session", 64'(want.ue_of_session), 64'(got.ue_of_session));
        check_field("uplink_bytes", want.uplink_bytes, got.uplink_bytes);
        check_field("downlink_bytes", want.downlink_bytes, got.downlink_bytes);
        check_field("qos_rate_kbps", 64'(want.qos_rate_kbps), 64'(got.qos_rate_kbps));
        check_field("total_uplink_bytes", want.total_uplink_bytes, got.total_uplink_bytes);
        check_field("total_downlink_bytes", want.total_downlink_bytes,
                    got.total_downlink_bytes);
        check_field("active_sessions", 64'(want.active_sessions), 64'(got.active_sessions));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    src_idle_pct = 32;
    sink_idle_pct = 87;
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    s_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
